// File: src/mbsp_pkg.sv
// Shared constants, message codes and parser state type for the MIDI byte stream parser.
package mbsp_pkg;

  localparam int ByteW = 8;
  localparam int KindW = 5;
  localparam int RkW   = 4;
  localparam int ChanW = 4;
  localparam int DataW = 7;

  localparam logic [RkW-1:0] RK_NONE     = 4'd0;
  localparam logic [RkW-1:0] RK_NOTEOFF  = 4'd1;
  localparam logic [RkW-1:0] RK_NOTEON   = 4'd2;
  localparam logic [RkW-1:0] RK_KEYPRESS = 4'd3;
  localparam logic [RkW-1:0] RK_CC       = 4'd4;
  localparam logic [RkW-1:0] RK_PROGRAM  = 4'd5;
  localparam logic [RkW-1:0] RK_CHANPRES = 4'd6;
  localparam logic [RkW-1:0] RK_BEND     = 4'd7;
  localparam logic [RkW-1:0] RK_SYSEX    = 4'd8;
  localparam logic [RkW-1:0] RK_MTC      = 4'd9;
  localparam logic [RkW-1:0] RK_SONGPOS  = 4'd10;
  localparam logic [RkW-1:0] RK_SONGSEL  = 4'd11;

  localparam logic [KindW-1:0] KIND_NOTE_OFF   = 5'd0;
  localparam logic [KindW-1:0] KIND_NOTE_ON    = 5'd1;
  localparam logic [KindW-1:0] KIND_KEYPRESS   = 5'd2;
  localparam logic [KindW-1:0] KIND_CC         = 5'd3;
  localparam logic [KindW-1:0] KIND_PROGRAM    = 5'd4;
  localparam logic [KindW-1:0] KIND_CHANPRES   = 5'd5;
  localparam logic [KindW-1:0] KIND_BEND       = 5'd6;
  localparam logic [KindW-1:0] KIND_SYSEX      = 5'd7;
  localparam logic [KindW-1:0] KIND_MTC        = 5'd8;
  localparam logic [KindW-1:0] KIND_SONGPOS    = 5'd9;
  localparam logic [KindW-1:0] KIND_SONGSEL    = 5'd10;
  localparam logic [KindW-1:0] KIND_TUNE       = 5'd11;
  localparam logic [KindW-1:0] KIND_EOX        = 5'd12;
  localparam logic [KindW-1:0] KIND_CLOCK      = 5'd13;
  localparam logic [KindW-1:0] KIND_START      = 5'd14;
  localparam logic [KindW-1:0] KIND_CONTINUE   = 5'd15;
  localparam logic [KindW-1:0] KIND_STOP       = 5'd16;
  localparam logic [KindW-1:0] KIND_SENSE      = 5'd17;
  localparam logic [KindW-1:0] KIND_RESET      = 5'd18;
  localparam logic [KindW-1:0] KIND_MODE_BASE  = 5'd19;
  localparam logic [KindW-1:0] KIND_MAX        = 5'd26;

  localparam logic [3:0] SYS_HI      = 4'hF;
  localparam logic [3:0] SYS_SYSEX   = 4'h0;
  localparam logic [3:0] SYS_MTC     = 4'h1;
  localparam logic [3:0] SYS_SONGPOS = 4'h2;
  localparam logic [3:0] SYS_SONGSEL = 4'h3;
  localparam logic [3:0] SYS_TUNE    = 4'h6;
  localparam logic [3:0] SYS_EOX     = 4'h7;
  localparam logic [3:0] SYS_CLOCK   = 4'h8;
  localparam logic [3:0] SYS_START   = 4'hA;
  localparam logic [3:0] SYS_CONT    = 4'hB;
  localparam logic [3:0] SYS_STOP    = 4'hC;
  localparam logic [3:0] SYS_SENSE   = 4'hE;
  localparam logic [3:0] SYS_RESET   = 4'hF;

  localparam logic [3:0] MODE_CC_HI = 4'hF;

  typedef struct packed {
    logic [RkW-1:0]   kind;
    logic [ChanW-1:0] chan;
    logic             cnt;
    logic [DataW-1:0] first;
  } run_state_t;

endpackage

// File: src/mbsp_if.sv
// Valid/ready channel interfaces for the MIDI byte input and message kind output.
interface mbsp_in_if import mbsp_pkg::*;;
  logic             valid;
  logic             ready;
  logic [ByteW-1:0] midi_byte;

  modport source (output valid, output midi_byte, input ready);
  modport sink (input valid, input midi_byte, output ready);
endinterface

interface mbsp_out_if import mbsp_pkg::*;;
  logic             valid;
  logic             ready;
  logic [KindW-1:0] msg_kind;

  modport source (output valid, output msg_kind, input ready);
  modport sink (input valid, input msg_kind, output ready);
endinterface

// File: src/mbsp_decode.sv
// Combinational decode of one MIDI byte against the running status state.
module mbsp_decode import mbsp_pkg::*; (
  input  logic [ByteW-1:0] midi_byte,
  input  run_state_t       cur,
  output run_state_t       nxt,
  output logic             emit,
  output logic [KindW-1:0] kind
);

  logic [DataW-1:0] data;
  logic             pair_done;

  assign data      = midi_byte[DataW-1:0];
  assign pair_done = cur.cnt;

  always_comb begin
    nxt  = cur;
    emit = 1'b0;
    kind = KIND_NOTE_OFF;
    if (midi_byte[7]) begin
      if (midi_byte[7:4] != SYS_HI) begin
        nxt.kind = {1'b0, midi_byte[6:4]} + 4'd1;
        nxt.chan = midi_byte[3:0];
        nxt.cnt  = 1'b0;
      end else begin
        unique case (midi_byte[3:0])
          SYS_SYSEX: begin
            nxt.kind = RK_SYSEX;
            nxt.cnt  = 1'b0;
            emit     = 1'b1;
            kind     = KIND_SYSEX;
          end
          SYS_MTC, SYS_SONGPOS, SYS_SONGSEL: begin
            nxt.kind = RK_MTC + {2'b00, midi_byte[1:0]} - 4'd1;
            nxt.chan = '0;
            nxt.cnt  = 1'b0;
          end
          SYS_TUNE, SYS_EOX: begin
            nxt.kind = RK_NONE;
            nxt.chan = '0;
            nxt.cnt  = 1'b0;
            emit     = 1'b1;
            kind     = midi_byte[0] ? KIND_EOX : KIND_TUNE;
          end
          SYS_CLOCK: begin
            emit = 1'b1;
            kind = KIND_CLOCK;
          end
          SYS_START: begin
            emit = 1'b1;
            kind = KIND_START;
          end
          SYS_CONT: begin
            emit = 1'b1;
            kind = KIND_CONTINUE;
          end
          SYS_STOP: begin
            emit = 1'b1;
            kind = KIND_STOP;
          end
          SYS_SENSE: begin
            emit = 1'b1;
            kind = KIND_SENSE;
          end
          SYS_RESET: begin
            emit = 1'b1;
            kind = KIND_RESET;
          end
          default: begin
          end
        endcase
      end
    end else begin
      unique case (cur.kind)
        RK_NOTEOFF, RK_NOTEON, RK_KEYPRESS, RK_CC, RK_BEND, RK_SONGPOS: begin
          if (!pair_done) begin
            nxt.first = data;
            nxt.cnt   = 1'b1;
          end else begin
            nxt.cnt = 1'b0;
            emit    = 1'b1;
            unique case (cur.kind)
              RK_NOTEOFF:  kind = KIND_NOTE_OFF;
              RK_NOTEON:   kind = (data == '0) ? KIND_NOTE_OFF : KIND_NOTE_ON;
              RK_KEYPRESS: kind = KIND_KEYPRESS;
              RK_CC: begin
                if (cur.first[6:3] == MODE_CC_HI) begin
                  kind = KIND_MODE_BASE + {2'b00, cur.first[2:0]};
                end else begin
                  kind = KIND_CC;
                end
              end
              RK_BEND:     kind = KIND_BEND;
              default: begin
                nxt.kind = RK_NONE;
                kind     = KIND_SONGPOS;
              end
            endcase
          end
        end
        RK_PROGRAM: begin
          nxt.cnt = 1'b0;
          emit    = 1'b1;
          kind    = KIND_PROGRAM;
        end
        RK_CHANPRES: begin
          nxt.cnt = 1'b0;
          emit    = 1'b1;
          kind    = KIND_CHANPRES;
        end
        RK_MTC: begin
          nxt.kind = RK_NONE;
          nxt.cnt  = 1'b0;
          emit     = 1'b1;
          kind     = KIND_MTC;
        end
        RK_SONGSEL: begin
          nxt.kind = RK_NONE;
          nxt.cnt  = 1'b0;
          emit     = 1'b1;
          kind     = KIND_SONGSEL;
        end
        default: begin
        end
      endcase
    end
  end

endmodule

// File: src/midi_byte_stream_parser.sv
// Top level of the MIDI 1.0 byte stream parser with running status.
// A byte accepted into the input register is decoded from there into the result register.
// Throughput: one byte per cycle; the input register and the result register
// decouple the two channels, so a stalled result only stops input once both are full.
// Reset (synchronous, active low) empties both registers and clears the running status.
module midi_byte_stream_parser import mbsp_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  mbsp_in_if.sink    in_ch,
  mbsp_out_if.source out_ch
);

  logic             in_v_r;
  logic [ByteW-1:0] in_byte_r;
  logic             out_v_r;
  logic [KindW-1:0] out_kind_r;
  run_state_t       state_r;
  run_state_t       state_nxt;
  logic             emit;
  logic [KindW-1:0] kind_nxt;
  logic             advance;
  logic             in_take;

  assign advance      = in_v_r && (!out_v_r || out_ch.ready);
  assign in_ch.ready  = !in_v_r || advance;
  assign in_take      = in_ch.valid && in_ch.ready;
  assign out_ch.valid = out_v_r;
  assign out_ch.msg_kind = out_kind_r;

  mbsp_decode u_decode (
    .midi_byte (in_byte_r),
    .cur       (state_r),
    .nxt       (state_nxt),
    .emit      (emit),
    .kind      (kind_nxt)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_v_r  <= 1'b0;
      out_v_r <= 1'b0;
      state_r <= '{kind: RK_NONE, chan: '0, cnt: 1'b0, first: '0};
    end else begin
      if (in_take) begin
        in_v_r <= 1'b1;
      end else if (advance) begin
        in_v_r <= 1'b0;
      end
      if (advance) begin
        out_v_r <= emit;
        state_r <= state_nxt;
      end else if (out_ch.ready) begin
        out_v_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      in_byte_r <= in_ch.midi_byte;
    end
    if (advance && emit) begin
      out_kind_r <= kind_nxt;
    end
  end

endmodule

// File: src/mbsp_checker.sv
// Port-level assertions for the MIDI byte stream parser, bound to the top level.
module mbsp_checker import mbsp_pkg::*; (
  input logic             clk,
  input logic             rst_n,
  input logic             in_valid,
  input logic             in_ready,
  input logic             out_valid,
  input logic             out_ready,
  input logic [KindW-1:0] msg_kind
);

  // A waiting result must not vanish or change before it is taken.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(msg_kind))
    else $error("result beat dropped or changed while stalled");

  // Reset empties the result register.
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");

  // Only defined message kinds are reported.
  a_kind_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> msg_kind <= KIND_MAX)
    else $error("message kind out of range");

  // Input is only held off while a result is stalled.
  a_no_needless_stall: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_valid || out_ready) |-> in_ready)
    else $error("input stalled with the result side free");

  // An idle input with a free result side leaves nothing to report once both registers have drained.
  a_no_invented: assert property (@(posedge clk) disable iff (!rst_n)
    (!in_valid && (!out_valid || out_ready)) [*2] |=> !out_valid)
    else $error("result beat without an input beat");

endmodule

bind midi_byte_stream_parser mbsp_checker u_mbsp_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_ch.valid),
  .in_ready  (in_ch.ready),
  .out_valid (out_ch.valid),
  .out_ready (out_ch.ready),
  .msg_kind  (out_ch.msg_kind)
);

// File: verif/tb_midi_byte_stream_parser.sv
// Self-checking regression testbench for the MIDI byte stream parser.
`timescale 1ns / 1ps

module tb_midi_byte_stream_parser;
  import mbsp_pkg::*;

  localparam int RandBytes  = 1400;
  localparam int CycleLimit = 200000;
  localparam int DrainWait  = 12;

  typedef struct packed {
    logic             hold;
    logic [ByteW-1:0] b;
  } stim_item_t;

  typedef struct packed {
    logic             hit;
    logic [KindW-1:0] kind;
  } kind_pred_t;

  logic clk;
  logic rst_n;

  mbsp_in_if  in_ch ();
  mbsp_out_if out_ch ();

  midi_byte_stream_parser u_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch.sink),
    .out_ch (out_ch.source)
  );

  stim_item_t       byte_q[$];
  logic [KindW-1:0] kind_q[$];
  run_state_t       parse_st;
  stim_item_t       next_item;
  kind_pred_t       pred;
  logic             in_taken;
  logic [26:0]      kinds_seen;
  int               cyc;
  int               err_cnt;
  int               bytes_queued;
  int               bytes_taken;
  int               kinds_checked;
  int               stim_cnt;
  logic             steady;

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // The parser keeps running status across beats; parse_st tracks it, and emit builds a predicted kind.
  function automatic kind_pred_t emit(input logic [KindW-1:0] k);
    kind_pred_t r;
    r.hit  = 1'b1;
    r.kind = k;
    return r;
  endfunction

  function automatic logic pair_done(input logic [DataW-1:0] d);
    if (!parse_st.cnt) begin
      parse_st.first = d;
      parse_st.cnt   = 1'b1;
      return 1'b0;
    end
    parse_st.cnt = 1'b0;
    return 1'b1;
  endfunction

  function automatic kind_pred_t decode_byte(input logic [ByteW-1:0] b);
    kind_pred_t       r;
    logic [DataW-1:0] d;
    r.hit  = 1'b0;
    r.kind = KIND_NOTE_OFF;
    d      = b[DataW-1:0];
    if (b[7]) begin
      if (b[7:4] != SYS_HI) begin
        parse_st.kind = {1'b0, b[6:4]} + RK_NOTEOFF;
        parse_st.chan = b[3:0];
        parse_st.cnt  = 1'b0;
      end else begin
        case (b[3:0])
          SYS_SYSEX: begin
            parse_st.kind = RK_SYSEX;
            parse_st.cnt  = 1'b0;
            r = emit(KIND_SYSEX);
          end
          SYS_MTC, SYS_SONGPOS, SYS_SONGSEL: begin
            parse_st.kind = RK_MTC + (b[3:0] - SYS_MTC);
            parse_st.chan = '0;
            parse_st.cnt  = 1'b0;
          end
          SYS_TUNE, SYS_EOX: begin
            parse_st.kind = RK_NONE;
            parse_st.chan = '0;
            parse_st.cnt  = 1'b0;
            r = emit((b[3:0] == SYS_TUNE) ? KIND_TUNE : KIND_EOX);
          end
          SYS_CLOCK: r = emit(KIND_CLOCK);
          SYS_START: r = emit(KIND_START);
          SYS_CONT:  r = emit(KIND_CONTINUE);
          SYS_STOP:  r = emit(KIND_STOP);
          SYS_SENSE: r = emit(KIND_SENSE);
          SYS_RESET: r = emit(KIND_RESET);
          default: ;
        endcase
      end
    end else begin
      case (parse_st.kind)
        RK_NOTEOFF:  if (pair_done(d)) r = emit(KIND_NOTE_OFF);
        RK_NOTEON:   if (pair_done(d)) r = emit((d == '0) ? KIND_NOTE_OFF : KIND_NOTE_ON);
        RK_KEYPRESS: if (pair_done(d)) r = emit(KIND_KEYPRESS);
        RK_CC: begin
          if (pair_done(d)) begin
            r = emit((parse_st.first[6:3] == MODE_CC_HI) ?
                     KIND_MODE_BASE + {2'b00, parse_st.first[2:0]} : KIND_CC);
          end
        end
        RK_PROGRAM: begin
          parse_st.cnt = 1'b0;
          r = emit(KIND_PROGRAM);
        end
        RK_CHANPRES: begin
          parse_st.cnt = 1'b0;
          r = emit(KIND_CHANPRES);
        end
        RK_BEND: if (pair_done(d)) r = emit(KIND_BEND);
        RK_MTC: begin
          parse_st.kind = RK_NONE;
          parse_st.cnt  = 1'b0;
          r = emit(KIND_MTC);
        end
        RK_SONGPOS: begin
          if (pair_done(d)) begin
            parse_st.kind = RK_NONE;
            r = emit(KIND_SONGPOS);
          end
        end
        RK_SONGSEL: begin
          parse_st.kind = RK_NONE;
          parse_st.cnt  = 1'b0;
          r = emit(KIND_SONGSEL);
        end
        default: ;
      endcase
    end
    return r;
  endfunction

  function automatic void log_error(input string msg);
    err_cnt++;
    if (err_cnt <= 10) $display("ERROR @%0d: %s", cyc, msg);
  endfunction

  always @(posedge clk) begin
    cyc++;
    if (cyc > CycleLimit) begin
      $display("Timed out after %0d cycles with %0d kinds outstanding.", cyc, kind_q.size());
      $display("midi_byte_stream_parser regression: fail");
      $finish;
    end else begin
      in_taken = rst_n && in_ch.valid && in_ch.ready;
      if (!rst_n) begin
        parse_st = '0;
      end else if (in_taken) begin
        bytes_taken++;
        pred = decode_byte(in_ch.midi_byte);
        if (pred.hit) kind_q.push_back(pred.kind);
      end
      if (rst_n && out_ch.valid && out_ch.ready) begin
        if (kind_q.size() == 0) begin
          log_error($sformatf("unexpected message kind %0d", out_ch.msg_kind));
        end else if (out_ch.msg_kind !== kind_q[0]) begin
          log_error($sformatf("msg_kind expected %0d, got %0d", kind_q[0], out_ch.msg_kind));
          void'(kind_q.pop_front());
        end else begin
          kinds_checked++;
          if (out_ch.msg_kind <= KIND_MAX) kinds_seen[out_ch.msg_kind] = 1'b1;
          void'(kind_q.pop_front());
        end
      end
    end
  end

  always @(negedge clk) begin
    steady = (cyc >= 600) && (cyc < 1000);
    if (!rst_n) begin
      in_ch.valid     <= 1'b0;
      in_ch.midi_byte <= '0;
      out_ch.ready    <= 1'b0;
    end else begin
      out_ch.ready <= steady || ($urandom_range(0, 99) >= 20);
      if (!in_ch.valid || in_taken) begin
        if (byte_q.size() != 0 && byte_q[0].hold) begin
          in_ch.valid <= 1'b0;
          if (kind_q.size() == 0) void'(byte_q.pop_front());
        end else if (byte_q.size() != 0 && (steady || $urandom_range(0, 99) >= 20)) begin
          next_item        = byte_q.pop_front();
          in_ch.valid     <= 1'b1;
          in_ch.midi_byte <= next_item.b;
        end else begin
          in_ch.valid <= 1'b0;
        end
      end
    end
  end

  task automatic add_byte(input logic [ByteW-1:0] b);
    stim_item_t it;
    it.hold = 1'b0;
    it.b    = b;
    byte_q.push_back(it);
    bytes_queued++;
  endtask

  task automatic add_hold();
    stim_item_t it;
    it = '0;
    it.hold = 1'b1;
    byte_q.push_back(it);
  endtask

  function automatic logic [ByteW-1:0] rand_data();
    int pick;
    pick = $urandom_range(0, 99);
    if (pick < 25) return ByteW'($urandom_range(120, 127));
    if (pick < 35) return '0;
    return ByteW'($urandom_range(0, 127));
  endfunction

  function automatic logic [ByteW-1:0] rand_realtime();
    case ($urandom_range(0, 5))
      0: return {SYS_HI, SYS_CLOCK};
      1: return {SYS_HI, SYS_START};
      2: return {SYS_HI, SYS_CONT};
      3: return {SYS_HI, SYS_STOP};
      4: return {SYS_HI, SYS_SENSE};
      default: return {SYS_HI, SYS_RESET};
    endcase
  endfunction

  task automatic add_data_run(input int n);
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(0, 99) < 10) add_byte(rand_realtime());
      add_byte(rand_data());
    end
  endtask

  initial begin
    logic [ByteW-1:0] status;
    int               sel;
    int               data_per_msg;
    rst_n           = 1'b0;
    in_ch.valid     = 1'b0;
    in_ch.midi_byte = '0;
    out_ch.ready    = 1'b0;
    in_taken        = 1'b0;
    parse_st        = '0;
    kinds_seen      = '0;
    cyc             = 0;
    err_cnt         = 0;
    bytes_queued    = 0;
    bytes_taken     = 0;
    kinds_checked   = 0;
    steady          = 1'b0;

    add_byte(8'h00);
    add_byte(8'h90);
    add_byte(8'h3C);
    add_byte(8'h00);
    add_byte(8'h7F);
    add_byte({SYS_HI, SYS_CLOCK});
    add_byte(8'h7F);
    add_byte(8'hB5);
    add_byte(8'h78);
    add_byte(8'h00);
    add_byte(8'h7F);
    add_byte(8'h77);
    add_byte(8'hF4);
    add_byte({SYS_HI, SYS_SYSEX});
    add_byte(8'h12);
    add_byte({SYS_HI, SYS_EOX});
    add_byte({SYS_HI, SYS_MTC});
    add_byte(8'h20);
    add_byte({SYS_HI, SYS_SONGPOS});
    add_byte(8'h01);
    add_byte(8'h02);
    add_byte({SYS_HI, SYS_SONGSEL});
    add_byte(8'h05);
    add_byte(8'hEF);
    add_byte(8'h00);
    add_byte(8'h7F);
    add_byte({SYS_HI, SYS_TUNE});
    add_byte({SYS_HI, SYS_RESET});
    add_hold();

    stim_cnt = 0;
    while (stim_cnt < RandBytes) begin
      sel = $urandom_range(0, 99);
      if (sel < 55) begin
        status = ByteW'($urandom_range(8'h80, 8'hEF));
        add_byte(status);
        data_per_msg = ((status[6:4] == 3'd4) || (status[6:4] == 3'd5)) ? 1 : 2;
        add_data_run(data_per_msg * $urandom_range(1, 3));
      end else if (sel < 65) begin
        add_byte({SYS_HI, SYS_SYSEX});
        add_data_run($urandom_range(0, 6));
        if ($urandom_range(0, 99) < 80) add_byte({SYS_HI, SYS_EOX});
      end else if (sel < 75) begin
        case ($urandom_range(0, 3))
          0: begin add_byte({SYS_HI, SYS_MTC}); add_data_run(1); end
          1: begin add_byte({SYS_HI, SYS_SONGPOS}); add_data_run(2); end
          2: begin add_byte({SYS_HI, SYS_SONGSEL}); add_data_run(1); end
          default: add_byte({SYS_HI, SYS_TUNE});
        endcase
      end else if (sel < 85) begin
        add_byte(rand_realtime());
      end else begin
        add_byte(ByteW'($urandom_range(0, 255)));
      end
      if (bytes_queued - stim_cnt > 400) begin
        add_hold();
        stim_cnt = bytes_queued;
      end
      if (bytes_queued > stim_cnt + 0) stim_cnt = stim_cnt;
      if (bytes_queued >= RandBytes + 28) stim_cnt = RandBytes;
    end

    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    while (bytes_taken < bytes_queued) @(posedge clk);
    while (kind_q.size() != 0) @(posedge clk);
    repeat (DrainWait) @(posedge clk);

    $display("Drove %0d bytes and checked %0d message kinds; %0d of 27 kinds were seen.",
             bytes_taken, kinds_checked, $countones(kinds_seen));
    if (err_cnt == 0) begin
      $display("midi_byte_stream_parser regression: pass");
    end else begin
      $display("%0d mismatches in total.", err_cnt);
      $display("midi_byte_stream_parser regression: fail");
    end
    $finish;
  end

endmodule
